FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the IR mark/space encoder.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define IRMSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define IRMSE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/irmse_pkg.sv
// Protocol codes and pulse timings for the IR mark/space encoder.
// Depends on nothing; imported by ir_remote_mark_space_encoder.
package irmse_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned MarkW  = 14;
  localparam int unsigned SpaceW = 13;
  localparam int unsigned CntW   = 6;

  localparam logic [OpW-1:0] OpNec       = 3'd0;
  localparam logic [OpW-1:0] OpNecRepeat = 3'd1;
  localparam logic [OpW-1:0] OpSamsung   = 3'd2;
  localparam logic [OpW-1:0] OpSony      = 3'd3;
  localparam logic [OpW-1:0] OpRc5       = 3'd4;

  // Durations in microseconds.
  localparam logic [MarkW-1:0]  MarkNecHdr     = 14'd9000;
  localparam logic [MarkW-1:0]  MarkSamsungHdr = 14'd4500;
  localparam logic [MarkW-1:0]  MarkUnit       = 14'd562;
  localparam logic [MarkW-1:0]  MarkSonyHdr    = 14'd2400;
  localparam logic [MarkW-1:0]  MarkSonyZero   = 14'd600;
  localparam logic [MarkW-1:0]  MarkSonyOne    = 14'd1200;
  localparam logic [MarkW-1:0]  MarkRc5Half    = 14'd889;
  localparam logic [MarkW-1:0]  MarkRc5Full    = 14'd1778;

  localparam logic [SpaceW-1:0] SpaceHdr       = 13'd4500;
  localparam logic [SpaceW-1:0] SpaceRepeat    = 13'd2250;
  localparam logic [SpaceW-1:0] SpaceZero      = 13'd562;
  localparam logic [SpaceW-1:0] SpaceOne       = 13'd1687;
  localparam logic [SpaceW-1:0] SpaceSony      = 13'd600;
  localparam logic [SpaceW-1:0] SpaceRc5Half   = 13'd889;
  localparam logic [SpaceW-1:0] SpaceRc5Full   = 13'd1778;

  // Pair positions that end a frame, and the RC5 half-bit count.
  localparam logic [CntW-1:0] NecStopIdx  = 6'd33;
  localparam logic [CntW-1:0] SonyLastIdx = 6'd12;
  localparam logic [CntW-1:0] Rc5Levels   = 6'd27;

endpackage

FILE: rtl/core/ir_remote_mark_space_encoder.sv
// IR remote frame encoder: turns one frame request into mark/space pairs.
// Depends on irmse_pkg and assert_macros.svh.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o   | opcode, device_address, command_code, toggle
//  out     | out_valid_o / out_ready_i | mark_time, space_time, last_pair
//
// A request is taken whenever no frame is being generated, even while the
// final pair of the previous frame still waits in the output register.
// Pairs are produced one per cycle from a shift register: NEC and Samsung give 34 pairs,
// NEC repeat 2, Sony 13 and RC5 between 8 and 14.
// A stalled output register holds the generator; unused opcodes produce no transfer.
// Reset returns the block to idle with the output register empty.

`include "assert_macros.svh"

module ir_remote_mark_space_encoder import irmse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        opcode_i,
  input  logic [15:0]       device_address_i,
  input  logic [7:0]        command_code_i,
  input  logic              toggle_bit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MarkW-1:0]  mark_time_o,
  output logic [SpaceW-1:0] space_time_o,
  output logic              last_pair_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic              state_q, state_d;
  logic [OpW-1:0]    proto_q, proto_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       sh_q, sh_d;
  logic              out_valid_q, out_valid_d;
  logic [MarkW-1:0]  mark_q, mark_d;
  logic [SpaceW-1:0] space_q, space_d;
  logic              last_q, last_d;

  logic              in_fire, gen_en;
  logic [MarkW-1:0]  pair_mark;
  logic [SpaceW-1:0] pair_space;
  logic              pair_last;
  logic [2:0]        step;
  logic              rc5_m2, rc5_s1, rc5_s2;
  logic [7:0]        ncmd, nec_hi;
  logic [13:0]       rc5_frame;
  logic [27:0]       rc5_lv;
  logic              run_rc5, run_pulse, ends_frame;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign gen_en     = (state_q == StRun) && (!out_valid_q || out_ready_i);

  assign ncmd   = ~command_code_i;
  assign nec_hi = (device_address_i[15:8] == 8'd0) ? ~device_address_i[7:0]
                                                   : device_address_i[15:8];
  assign rc5_frame = {2'b11, toggle_bit_i, device_address_i[4:0], command_code_i[5:0]};

  // Manchester half-bits, first-sent level in bit 0: a one is space then mark.
  always_comb begin
    for (int j = 0; j < 14; j++) begin
      rc5_lv[2*j]   = ~rc5_frame[13-j];
      rc5_lv[2*j+1] = rc5_frame[13-j];
    end
  end

  // RC5 runs are at most two half-bits long, so a window of four levels decides a pair.
  always_comb begin
    rc5_m2 = (cnt_q >= 6'd2) && sh_q[1];
    if (rc5_m2) begin
      rc5_s1 = (cnt_q > 6'd2) && !sh_q[2];
      rc5_s2 = rc5_s1 && (cnt_q > 6'd3) && !sh_q[3];
    end else begin
      rc5_s1 = (cnt_q > 6'd1) && !sh_q[1];
      rc5_s2 = rc5_s1 && (cnt_q > 6'd2) && !sh_q[2];
    end
  end

  always_comb begin
    pair_mark  = '0;
    pair_space = '0;
    pair_last  = 1'b0;
    step       = 3'd0;
    cnt_d      = cnt_q + 6'd1;
    case (proto_q)
      OpNec, OpSamsung: begin
        if (cnt_q == 6'd0) begin
          pair_mark  = (proto_q == OpNec) ? MarkNecHdr : MarkSamsungHdr;
          pair_space = SpaceHdr;
        end else if (cnt_q == NecStopIdx) begin
          pair_mark = MarkUnit;
          pair_last = 1'b1;
        end else begin
          pair_mark  = MarkUnit;
          pair_space = sh_q[0] ? SpaceOne : SpaceZero;
          step       = 3'd1;
        end
      end
      OpNecRepeat: begin
        if (cnt_q == 6'd0) begin
          pair_mark  = MarkNecHdr;
          pair_space = SpaceRepeat;
        end else begin
          pair_mark = MarkUnit;
          pair_last = 1'b1;
        end
      end
      OpSony: begin
        if (cnt_q == 6'd0) begin
          pair_mark  = MarkSonyHdr;
          pair_space = SpaceSony;
        end else begin
          pair_mark  = sh_q[0] ? MarkSonyOne : MarkSonyZero;
          pair_last  = (cnt_q == SonyLastIdx);
          pair_space = pair_last ? '0 : SpaceSony;
          step       = 3'd1;
        end
      end
      OpRc5: begin
        // Here the counter holds the number of half-bits still to send.
        step       = (rc5_m2 ? 3'd2 : 3'd1) + (rc5_s2 ? 3'd2 : (rc5_s1 ? 3'd1 : 3'd0));
        pair_mark  = rc5_m2 ? MarkRc5Full : MarkRc5Half;
        pair_last  = (cnt_q == {3'b000, step});
        pair_space = pair_last ? '0 : (rc5_s2 ? SpaceRc5Full : SpaceRc5Half);
        cnt_d      = cnt_q - {3'b000, step};
      end
      default: begin
        pair_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    proto_d     = proto_q;
    sh_d        = sh_q;
    out_valid_d = out_valid_q;
    mark_d      = mark_q;
    space_d     = space_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      proto_d = opcode_i;
      if (opcode_i <= OpRc5) begin
        state_d = StRun;
      end
      case (opcode_i)
        OpNec:     sh_d = {ncmd, command_code_i, nec_hi, device_address_i[7:0]};
        OpSamsung: sh_d = {ncmd, command_code_i, device_address_i[7:0],
                           device_address_i[7:0]};
        OpSony:    sh_d = {20'd0, device_address_i[4:0], command_code_i[6:0]};
        // The leading space of the start bit is never sent.
        OpRc5:     sh_d = {5'd0, rc5_lv[27:1]};
        default:   sh_d = sh_q;
      endcase
    end else if (gen_en) begin
      out_valid_d = 1'b1;
      mark_d      = pair_mark;
      space_d     = pair_space;
      last_d      = pair_last;
      sh_d        = sh_q >> step;
      if (pair_last) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      proto_q     <= OpNec;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      proto_q     <= proto_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        cnt_q <= (opcode_i == OpRc5) ? Rc5Levels : '0;
      end else if (gen_en) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    mark_q  <= mark_d;
    space_q <= space_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign mark_time_o  = mark_q;
  assign space_time_o = space_q;
  assign last_pair_o  = last_q;

  assign run_rc5    = (state_q == StRun) && (proto_q == OpRc5);
  assign run_pulse  = (state_q == StRun) && (proto_q != OpRc5);
  assign ends_frame = gen_en && pair_last;

  `IRMSE_ASSERT(a_rc5_levels_bounded, !run_rc5 || cnt_q <= Rc5Levels, "RC5 count out of range")
  `IRMSE_ASSERT(a_pulse_count_bounded, !run_pulse || cnt_q <= NecStopIdx, "pair count too high")
  `IRMSE_ASSERT(a_final_space_zero, !out_valid_q || !last_q || space_q == '0, "last space set")
  `IRMSE_ASSERT_NEXT(a_frame_closes, ends_frame, in_ready_o && out_valid_q && last_q, "open frame")

endmodule
